@@ design/gle_pkg.sv @@
package gle_pkg;

    localparam logic [11:0] CODE_CLEAR  = 12'd256;
    localparam logic [11:0] CODE_EOI    = 12'd257;
    localparam logic [12:0] FIRST_FREE  = 13'd258;
    localparam logic [3:0]  START_WIDTH = 4'd9;
    localparam logic [3:0]  MAX_WIDTH   = 4'd12;
    localparam logic [7:0]  MIN_CODE_SIZE = 8'd8;
    localparam logic [31:0] HASH_MULT   = 32'd2654435761;

    localparam int KEY_W   = 20;
    localparam int CODE_W  = 12;
    localparam int TAG_W   = 8;
    localparam int ENTRY_W = TAG_W + KEY_W + CODE_W;

    typedef enum logic
    {
        CMD_HEADER,
        CMD_CODE
    } gle_cmd_kind_t;

    typedef struct packed
    {
        logic [7:0] pix;
        logic       last;
        logic       first;
    } gle_item_t;

    typedef struct packed
    {
        gle_cmd_kind_t kind;
        logic [11:0]   code;
        logic [3:0]    width;
        logic          last;
    } gle_cmd_t;

endpackage

@@ design/gif_lzw_encoder_core.sv @@
// GIF LZW encoder for 8-bit palette indices.
// The input channel takes one pixel request per handshake: pixel_index and
// last_pixel, which marks the final pixel of a frame. The output channel
// delivers the stream one byte per request: the code size byte, then packed
// LZW data bytes with sub_block_end on every SUB_BLOCK_BYTES-th data byte and
// on the final byte, and frame_done on the final byte only.
// A two-entry input queue accepts requests while the dictionary engine works.
// A dictionary hit passes the engine states idle, hash, home, read, check and
// tail, each extra linear probe repeats read and check, as the hash and the
// dictionary memory read are registered. A miss adds emit and miss, a full
// dictionary emit and full. Each code waits while the packer holds a full byte.
// After reset, and after every 255th dictionary reset, the engine sweeps the
// dictionary memory, all HASH_SLOTS entries, and accepts no queued pixel then.
// When the receiver stalls, the output byte holds; the packer keeps at most
// two more bytes and then the engine and the input queue fill and stall.
module gif_lzw_encoder_core #(
    parameter int MAX_CODES       = 4096,
    parameter int HASH_SLOTS      = 8192,
    parameter int SUB_BLOCK_BYTES = 255
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] pixel_index,
    input  logic       last_pixel,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       byte_role,
    output logic       sub_block_end,
    output logic       frame_done
);
    import gle_pkg::*;

    logic      q_valid;
    logic      q_pop;
    gle_item_t q_item;
    logic      cmd_valid;
    logic      cmd_ready;
    gle_cmd_t  cmd;

    gle_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel_index (pixel_index),
        .last_pixel  (last_pixel),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_item      (q_item)
    );

    gle_back #(.MAX_CODES(MAX_CODES), .HASH_SLOTS(HASH_SLOTS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    gle_packer #(.SUB_BLOCK_BYTES(SUB_BLOCK_BYTES)) u_packer (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .byte_role     (byte_role),
        .sub_block_end (sub_block_end),
        .frame_done    (frame_done)
    );

endmodule

@@ design/gle_ram.sv @@
module gle_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/gle_front.sv @@
module gle_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          pixel_index,
    input  logic                last_pixel,
    output logic                q_valid,
    input  logic                q_pop,
    output gle_pkg::gle_item_t  q_item
);
    import gle_pkg::*;

    gle_item_t slot_reg [2];
    logic      wr_ptr_reg, wr_ptr_next;
    logic      rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic      open_reg, open_next;
    logic      push;
    logic      pop;

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
        open_next   = push ? !last_pixel : open_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
            open_reg   <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            open_reg   <= open_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= '{pix: pixel_index, last: last_pixel, first: !open_reg};
        end
    end

endmodule

@@ design/gle_back.sv @@
module gle_back #(
    parameter int MAX_CODES  = 4096,
    parameter int HASH_SLOTS = 8192
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_pop,
    input  gle_pkg::gle_item_t q_item,
    output logic               cmd_valid,
    input  logic               cmd_ready,
    output gle_pkg::gle_cmd_t  cmd
);
    import gle_pkg::*;

    localparam int AW = $clog2(HASH_SLOTS);

    typedef enum logic [3:0]
    {
        S_CLR,
        S_IDLE,
        S_HASH,
        S_HOME,
        S_RD,
        S_CHECK,
        S_EMIT,
        S_MISS,
        S_FULL,
        S_HDR2,
        S_TAIL,
        S_EOI
    } state_t;

    state_t      state_reg, state_next;
    state_t      after_reg, after_next;
    logic [11:0] cur_reg, cur_next;
    logic [12:0] nf_reg, nf_next;
    logic [3:0]  width_reg, width_next;
    logic [TAG_W-1:0] epoch_reg, epoch_next;
    logic        wrap_reg, wrap_next;
    logic        last_reg, last_next;
    logic [7:0]  pix_reg, pix_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [31:0] prod_reg, prod_next;
    logic [AW-1:0] slot_reg, slot_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic        cmd_valid_reg, cmd_valid_next;
    gle_cmd_t    cmd_reg, cmd_next;

    logic               we;
    logic [AW-1:0]      waddr;
    logic [ENTRY_W-1:0] wdata;
    logic [ENTRY_W-1:0] rdata;
    logic [TAG_W-1:0]   r_tag;
    logic [KEY_W-1:0]   r_key;
    logic [CODE_W-1:0]  r_code;

    gle_ram #(.WIDTH(ENTRY_W), .DEPTH(HASH_SLOTS)) u_dict (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (slot_reg),
        .rdata (rdata)
    );

    assign r_tag     = rdata[ENTRY_W-1 -: TAG_W];
    assign r_key     = rdata[CODE_W +: KEY_W];
    assign r_code    = rdata[CODE_W-1:0];
    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;
    assign q_pop     = (state_reg == S_IDLE) && q_valid;

    always_comb
    begin
        state_next     = state_reg;
        after_next     = after_reg;
        cur_next       = cur_reg;
        nf_next        = nf_reg;
        width_next     = width_reg;
        epoch_next     = epoch_reg;
        wrap_next      = wrap_reg;
        last_next      = last_reg;
        pix_next       = pix_reg;
        key_next       = key_reg;
        prod_next      = prod_reg;
        slot_next      = slot_reg;
        clr_next       = clr_reg;
        cmd_valid_next = cmd_valid_reg;
        cmd_next       = cmd_reg;
        we             = 1'b0;
        waddr          = slot_reg;
        wdata          = {epoch_reg, key_reg, nf_reg[CODE_W-1:0]};

        case (state_reg)
            S_CLR:
            begin
                we    = 1'b1;
                waddr = clr_reg;
                wdata = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(HASH_SLOTS - 1))
                begin
                    epoch_next = TAG_W'(1);
                    wrap_next  = 1'b0;
                    state_next = S_TAIL;
                end
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    pix_next  = q_item.pix;
                    last_next = q_item.last;
                    key_next  = {cur_reg, q_item.pix};
                    if (q_item.first)
                    begin
                        nf_next    = FIRST_FREE;
                        width_next = START_WIDTH;
                        if (epoch_reg == '1)
                        begin
                            wrap_next = 1'b1;
                        end
                        else
                        begin
                            epoch_next = epoch_reg + 1'b1;
                        end
                        cur_next       = {4'd0, q_item.pix};
                        cmd_valid_next = 1'b1;
                        cmd_next       = '{kind: CMD_HEADER, code: '0, width: '0, last: 1'b0};
                        after_next     = S_HDR2;
                        state_next     = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_HASH;
                    end
                end
            end
            S_HASH:
            begin
                prod_next  = {16'd0, key_reg[15:0]} * HASH_MULT;
                state_next = S_HOME;
            end
            S_HOME:
            begin
                slot_next  = prod_reg[AW-1:0];
                state_next = S_RD;
            end
            S_RD:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (r_tag == epoch_reg)
                begin
                    if (r_key == key_reg)
                    begin
                        cur_next   = r_code;
                        state_next = S_TAIL;
                    end
                    else
                    begin
                        slot_next  = slot_reg + 1'b1;
                        state_next = S_RD;
                    end
                end
                else
                begin
                    cmd_valid_next = 1'b1;
                    cmd_next   = '{kind: CMD_CODE, code: cur_reg, width: width_reg, last: 1'b0};
                    after_next = S_MISS;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (cmd_ready)
                begin
                    cmd_valid_next = 1'b0;
                    state_next     = after_reg;
                end
            end
            S_MISS:
            begin
                if (nf_reg < 13'(MAX_CODES))
                begin
                    we = 1'b1;
                    if (width_reg < MAX_WIDTH && nf_reg >= (13'd1 << width_reg))
                    begin
                        width_next = width_reg + 4'd1;
                    end
                    nf_next    = nf_reg + 13'd1;
                    cur_next   = {4'd0, pix_reg};
                    state_next = S_TAIL;
                end
                else
                begin
                    cmd_valid_next = 1'b1;
                    cmd_next   = '{kind: CMD_CODE, code: CODE_CLEAR, width: width_reg, last: 1'b0};
                    after_next = S_FULL;
                    state_next = S_EMIT;
                end
            end
            S_FULL:
            begin
                nf_next    = FIRST_FREE;
                width_next = START_WIDTH;
                if (epoch_reg == '1)
                begin
                    wrap_next = 1'b1;
                end
                else
                begin
                    epoch_next = epoch_reg + 1'b1;
                end
                cur_next   = {4'd0, pix_reg};
                state_next = S_TAIL;
            end
            S_HDR2:
            begin
                cmd_valid_next = 1'b1;
                cmd_next   = '{kind: CMD_CODE, code: CODE_CLEAR, width: width_reg, last: 1'b0};
                after_next = S_TAIL;
                state_next = S_EMIT;
            end
            S_TAIL:
            begin
                if (wrap_reg)
                begin
                    clr_next   = '0;
                    state_next = S_CLR;
                end
                else if (last_reg)
                begin
                    cmd_valid_next = 1'b1;
                    cmd_next   = '{kind: CMD_CODE, code: cur_reg, width: width_reg, last: 1'b0};
                    after_next = S_EOI;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_EOI:
            begin
                last_next      = 1'b0;
                cmd_valid_next = 1'b1;
                cmd_next   = '{kind: CMD_CODE, code: CODE_EOI, width: width_reg, last: 1'b1};
                after_next = S_IDLE;
                state_next = S_EMIT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            after_reg     <= S_IDLE;
            cur_reg       <= '0;
            nf_reg        <= FIRST_FREE;
            width_reg     <= START_WIDTH;
            epoch_reg     <= '0;
            wrap_reg      <= 1'b1;
            last_reg      <= 1'b0;
            clr_reg       <= '0;
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            after_reg     <= after_next;
            cur_reg       <= cur_next;
            nf_reg        <= nf_next;
            width_reg     <= width_next;
            epoch_reg     <= epoch_next;
            wrap_reg      <= wrap_next;
            last_reg      <= last_next;
            clr_reg       <= clr_next;
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg  <= pix_next;
        key_reg  <= key_next;
        prod_reg <= prod_next;
        slot_reg <= slot_next;
        cmd_reg  <= cmd_next;
    end

endmodule

@@ design/gle_packer.sv @@
module gle_packer #(
    parameter int SUB_BLOCK_BYTES = 255
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  gle_pkg::gle_cmd_t cmd,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        out_byte,
    output logic              byte_role,
    output logic              sub_block_end,
    output logic              frame_done
);
    import gle_pkg::*;

    logic [18:0] acc_reg, acc_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        flush_reg, flush_next;
    logic        hdr_reg, hdr_next;
    logic [7:0]  fill_reg, fill_next;
    logic        valid_reg, valid_next;
    logic [7:0]  byte_reg, byte_next;
    logic        role_reg, role_next;
    logic        end_reg, end_next;
    logic        done_reg, done_next;
    logic        out_free;
    logic        emit;
    logic        final_byte;
    logic [8:0]  fill_inc;

    assign cmd_ready     = !hdr_reg && (cnt_reg < 5'd8) && !flush_reg;
    assign out_free      = !valid_reg || !out_stall;
    assign out_valid     = valid_reg;
    assign out_byte      = byte_reg;
    assign byte_role     = role_reg;
    assign sub_block_end = end_reg;
    assign frame_done    = done_reg;
    assign fill_inc      = {1'b0, fill_reg} + 9'd1;

    always_comb
    begin
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        flush_next = flush_reg;
        hdr_next   = hdr_reg;
        fill_next  = fill_reg;
        valid_next = valid_reg && out_stall;
        byte_next  = byte_reg;
        role_next  = role_reg;
        end_next   = end_reg;
        done_next  = done_reg;
        emit       = 1'b0;
        final_byte = 1'b0;

        if (out_free)
        begin
            if (hdr_reg)
            begin
                hdr_next   = 1'b0;
                valid_next = 1'b1;
                byte_next  = MIN_CODE_SIZE;
                role_next  = 1'b0;
                end_next   = 1'b0;
                done_next  = 1'b0;
            end
            else if (cnt_reg >= 5'd8)
            begin
                emit       = 1'b1;
                final_byte = flush_reg && (cnt_reg == 5'd8);
                acc_next   = acc_reg >> 8;
                cnt_next   = cnt_reg - 5'd8;
            end
            else if (flush_reg && cnt_reg != 5'd0)
            begin
                emit       = 1'b1;
                final_byte = 1'b1;
                acc_next   = '0;
                cnt_next   = '0;
            end
        end

        if (emit)
        begin
            valid_next = 1'b1;
            byte_next  = acc_reg[7:0];
            role_next  = 1'b1;
            done_next  = final_byte;
            if (final_byte)
            begin
                end_next   = 1'b1;
                fill_next  = '0;
                flush_next = 1'b0;
            end
            else if (fill_inc >= 9'(SUB_BLOCK_BYTES))
            begin
                end_next  = 1'b1;
                fill_next = '0;
            end
            else
            begin
                end_next  = 1'b0;
                fill_next = fill_inc[7:0];
            end
        end

        if (cmd_valid && cmd_ready)
        begin
            case (cmd.kind)
                CMD_HEADER:
                begin
                    hdr_next = 1'b1;
                end
                CMD_CODE:
                begin
                    acc_next   = acc_reg | ({7'd0, cmd.code} << cnt_reg[2:0]);
                    cnt_next   = cnt_reg + {1'b0, cmd.width};
                    flush_next = cmd.last;
                end
                default:
                begin
                    hdr_next = hdr_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            cnt_reg   <= '0;
            flush_reg <= 1'b0;
            hdr_reg   <= 1'b0;
            fill_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            flush_reg <= flush_next;
            hdr_reg   <= hdr_next;
            fill_reg  <= fill_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        role_reg <= role_next;
        end_reg  <= end_next;
        done_reg <= done_next;
    end

endmodule

@@ design/gle_checker.sv @@
module gle_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       byte_role,
    input logic       sub_block_end,
    input logic       frame_done
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(frame_done))
        else $error("Stalled output request changed.");

    a_header: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_role |-> out_byte == 8'd8 && !sub_block_end && !frame_done)
        else $error("Code size byte is malformed.");

    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> byte_role && sub_block_end)
        else $error("Final byte is not a closing data byte.");

endmodule

bind gif_lzw_encoder_core gle_checker u_gle_checker (.*);
